[hdl/lpcg_pkg.sv]
// lpcg_pkg: types, constants and helper functions for the LED pixel color generator.
// No dependencies.
`timescale 1ns / 1ps
package lpcg_pkg;

    localparam int unsigned IDX_W = 10;

    typedef enum logic {
        CMD_HSV  = 1'b0,
        CMD_HEAT = 1'b1
    } t_cmd;

    typedef enum logic {
        GAMMA_LUT    = 1'b0,
        GAMMA_SQUARE = 1'b1
    } t_gamma_mode;

    typedef struct packed {
        logic [IDX_W-1:0] led_index;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       fade;
    } t_color;

    localparam logic [7:0] GAMMA_LUT_TBL [256] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
        8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3,
        8'd3, 8'd3, 8'd3, 8'd3, 8'd4, 8'd4, 8'd4, 8'd5,
        8'd5, 8'd5, 8'd5, 8'd5, 8'd6, 8'd6, 8'd6, 8'd6,
        8'd7, 8'd7, 8'd7, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8,
        8'd9, 8'd10, 8'd10, 8'd10, 8'd10, 8'd11, 8'd11, 8'd12,
        8'd12, 8'd12, 8'd12, 8'd13, 8'd13, 8'd13, 8'd14, 8'd14,
        8'd15, 8'd15, 8'd15, 8'd16, 8'd17, 8'd17, 8'd17, 8'd17,
        8'd18, 8'd18, 8'd19, 8'd20, 8'd20, 8'd20, 8'd20, 8'd21,
        8'd22, 8'd22, 8'd23, 8'd23, 8'd23, 8'd24, 8'd25, 8'd25,
        8'd26, 8'd26, 8'd27, 8'd27, 8'd28, 8'd28, 8'd29, 8'd30,
        8'd30, 8'd31, 8'd31, 8'd32, 8'd33, 8'd33, 8'd34, 8'd35,
        8'd35, 8'd36, 8'd37, 8'd37, 8'd38, 8'd38, 8'd39, 8'd40,
        8'd41, 8'd41, 8'd42, 8'd43, 8'd44, 8'd45, 8'd45, 8'd46,
        8'd47, 8'd47, 8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53,
        8'd54, 8'd54, 8'd55, 8'd56, 8'd56, 8'd57, 8'd58, 8'd59,
        8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd65, 8'd66, 8'd67,
        8'd68, 8'd69, 8'd69, 8'd70, 8'd71, 8'd73, 8'd74, 8'd75,
        8'd76, 8'd77, 8'd78, 8'd79, 8'd80, 8'd81, 8'd82, 8'd84,
        8'd85, 8'd86, 8'd87, 8'd89, 8'd90, 8'd91, 8'd93, 8'd94,
        8'd95, 8'd96, 8'd97, 8'd98, 8'd100, 8'd101, 8'd102, 8'd103,
        8'd105, 8'd106, 8'd108, 8'd109, 8'd110, 8'd111, 8'd113, 8'd115,
        8'd117, 8'd118, 8'd119, 8'd121, 8'd122, 8'd123, 8'd124, 8'd127,
        8'd128, 8'd130, 8'd131, 8'd133, 8'd134, 8'd136, 8'd137, 8'd139,
        8'd140, 8'd143, 8'd145, 8'd146, 8'd147, 8'd148, 8'd151, 8'd153,
        8'd154, 8'd156, 8'd158, 8'd159, 8'd162, 8'd163, 8'd165, 8'd167,
        8'd169, 8'd171, 8'd173, 8'd174, 8'd176, 8'd179, 8'd180, 8'd182,
        8'd185, 8'd186, 8'd188, 8'd190, 8'd192, 8'd194, 8'd196, 8'd199,
        8'd201, 8'd202, 8'd205, 8'd207, 8'd209, 8'd211, 8'd214, 8'd216,
        8'd218, 8'd220, 8'd223, 8'd225, 8'd226, 8'd230, 8'd231, 8'd235,
        8'd236, 8'd240, 8'd241, 8'd245, 8'd246, 8'd250, 8'd251, 8'd255
    };

    // 8x8 fade with +1 when both operands are nonzero
    function automatic logic [7:0] scale8(input logic [7:0] x, input logic [7:0] f);
        logic [15:0] p;
        p = x * f;
        return p[15:8] + {7'd0, (x != 8'd0) && (f != 8'd0)};
    endfunction

    function automatic logic [7:0] gamma(input logic [7:0] x, input logic mode);
        logic [16:0] sq;
        sq = 17'(x) * 17'(x) + 17'd255;
        return (mode == GAMMA_SQUARE) ? sq[15:8] : GAMMA_LUT_TBL[x];
    endfunction

    // x / 255 for x < 65280: (x + 1 + (x >> 8)) >> 8
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

    // x / 60 for x < 15360: reciprocal 1092/65536 never overshoots, one upward fixup
    function automatic logic [7:0] div60(input logic [13:0] x);
        logic [24:0] p;
        logic [7:0]  q;
        logic [13:0] rem;
        p   = x * 11'd1092;
        q   = p[23:16];
        rem = x - 14'(q * 6'd60);
        if (rem >= 14'd60) begin
            q = q + 8'd1;
        end
        return q;
    endfunction

endpackage

[hdl/lpcg_if.sv]
// lpcg_if: valid/ready stream interface carrying a payload of type T.
// Depends on nothing.
`timescale 1ns / 1ps
interface lpcg_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/lpcg_hsv.sv]
// lpcg_hsv: pipelined HSV / heat to RGB conversion, three register stages.
// Depends on lpcg_pkg.
`timescale 1ns / 1ps
module lpcg_hsv #(
    parameter int MAX_LEDS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_cmd,
    input  logic [7:0]                    i_hue,
    input  logic [7:0]                    i_saturation,
    input  logic [7:0]                    i_brightness,
    input  logic [7:0]                    i_temperature,
    input  logic [7:0]                    i_fade,
    input  logic [lpcg_pkg::IDX_W-1:0]    i_led_index,
    output logic                          o_valid,
    output lpcg_pkg::t_color              o_color
);
    import lpcg_pkg::*;

    localparam int unsigned MAXI = (MAX_LEDS > 1024) ? 1023 : MAX_LEDS - 1;

    function automatic logic [8:0] deg17(input logic [12:0] x);
        logic [25:0] p;
        logic [8:0]  q;
        logic [12:0] rem;
        p   = x * 13'd3855;
        q   = p[24:16];
        rem = x - 13'(q * 5'd17);
        if (rem >= 13'd17) begin
            q = q + 9'd1;
        end
        return q;
    endfunction

    // stage 1: degrees, span, heat scaling
    logic             r_v1, r_cmd1;
    logic [8:0]       r_deg1;
    logic [7:0]       r_span1, r_v1val, r_t1, r_fade1;
    logic [IDX_W-1:0] r_idx1;
    logic [12:0]      n_deg24;
    logic [IDX_W-1:0] n_idx;

    always_comb begin
        n_deg24 = 13'd24 * {5'd0, i_hue};
        n_idx   = (i_led_index > IDX_W'(MAXI)) ? IDX_W'(MAXI) : i_led_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_cmd1  <= i_cmd;
            // 24*h/17 < 361: x*3855>>16 with one correction
            r_deg1  <= deg17(n_deg24);
            r_span1 <= div255(i_brightness * i_saturation);
            r_v1val <= i_brightness;
            r_t1    <= scale8(i_temperature, 8'd191);
            r_fade1 <= i_fade;
            r_idx1  <= n_idx;
        end
    end

    // stage 2: sector, remainder product
    logic             r_v2, r_cmd2;
    logic [2:0]       r_sec2;
    logic [13:0]      r_prod2;
    logic [7:0]       r_span2, r_v2val, r_t2, r_fade2;
    logic [IDX_W-1:0] r_idx2;
    logic [7:0]       n_q;
    logic [8:0]       n_rem;
    logic [2:0]       n_sec;

    always_comb begin
        n_q   = div60({5'd0, r_deg1});
        n_rem = r_deg1 - 9'(n_q * 6'd60);
        n_sec = (n_q >= 8'd6) ? 3'(n_q - 8'd6) : n_q[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_cmd2  <= r_cmd1;
            r_sec2  <= n_sec;
            r_prod2 <= r_span1 * n_rem[5:0];
            r_span2 <= r_span1;
            r_v2val <= r_v1val;
            r_t2    <= r_t1;
            r_fade2 <= r_fade1;
            r_idx2  <= r_idx1;
        end
    end

    // stage 3: channel select
    logic [7:0] n_a, n_lo, n_up, n_dn, n_r, n_g, n_b, n_ramp;

    always_comb begin
        n_a    = div60(r_prod2);
        n_lo   = r_v2val - r_span2;
        n_up   = n_lo + n_a;
        n_dn   = r_v2val - n_a;
        n_ramp = {r_t2[5:0], 2'b00};
        if (r_cmd2 == CMD_HEAT) begin
            if (r_t2[7]) begin
                n_r = 8'd255; n_g = 8'd255; n_b = n_ramp;
            end else if (r_t2[6]) begin
                n_r = 8'd255; n_g = n_ramp; n_b = 8'd0;
            end else begin
                n_r = n_ramp; n_g = 8'd0; n_b = 8'd0;
            end
        end else begin
            case (r_sec2)
                3'd0: begin n_r = r_v2val; n_g = n_up; n_b = n_lo; end
                3'd1: begin n_r = n_dn; n_g = r_v2val; n_b = n_lo; end
                3'd2: begin n_r = n_lo; n_g = r_v2val; n_b = n_up; end
                3'd3: begin n_r = n_lo; n_g = n_dn; n_b = r_v2val; end
                3'd4: begin n_r = n_up; n_g = n_lo; n_b = r_v2val; end
                default: begin n_r = r_v2val; n_g = n_lo; n_b = n_dn; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v2;
        end
        if (i_en) begin
            o_color <= '{led_index: r_idx2, red: n_r, green: n_g, blue: n_b,
                         fade: r_fade2};
        end
    end
endmodule

[hdl/lpcg_correct.sv]
// lpcg_correct: fade scaling and gamma correction, two register stages.
// Depends on lpcg_pkg.
`timescale 1ns / 1ps
module lpcg_correct (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_gamma_mode,
    input  logic             i_valid,
    input  lpcg_pkg::t_color i_color,
    output logic             o_valid,
    output lpcg_pkg::t_color o_color
);
    import lpcg_pkg::*;

    logic   r_v;
    t_color r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v     <= i_valid;
            o_valid <= r_v;
        end
        if (i_en) begin
            r_c.led_index <= i_color.led_index;
            r_c.red       <= scale8(i_color.red, i_color.fade);
            r_c.green     <= scale8(i_color.green, i_color.fade);
            r_c.blue      <= scale8(i_color.blue, i_color.fade);
            r_c.fade      <= i_color.fade;
            o_color.led_index <= r_c.led_index;
            o_color.red       <= gamma(r_c.red, i_gamma_mode);
            o_color.green     <= gamma(r_c.green, i_gamma_mode);
            o_color.blue      <= gamma(r_c.blue, i_gamma_mode);
            o_color.fade      <= r_c.fade;
        end
    end
endmodule

[hdl/led_pixel_color_generator.sv]
// Throughput one pixel per cycle while the output is not stalled. Five register stages
// (convert x3, fade, gamma) advance together; a stalled output holds the whole pipeline,
// and an empty output slot lets it move.
// Reset (synchronous, active low) clears all valid bits and gamma_mode to 0.
// Depends on lpcg_pkg, lpcg_if, lpcg_hsv, lpcg_correct.
`timescale 1ns / 1ps
module led_pixel_color_generator #(
    parameter int MAX_LEDS = 1024
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lpcg_if.sink   i_pix,
    lpcg_if.sink   i_cfg,
    lpcg_if.source o_pix
);
    import lpcg_pkg::*;

    logic   r_gamma_mode;
    logic   en, v_mid;
    t_color c_mid, c_out;

    assign en          = !o_pix.valid || o_pix.ready;
    assign i_pix.ready = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma_mode <= GAMMA_LUT;
        end else if (i_cfg.valid) begin
            r_gamma_mode <= i_cfg.data;
        end
    end

    lpcg_hsv #(.MAX_LEDS(MAX_LEDS)) u_hsv (
        .i_clk, .i_rst_n, .i_en(en),
        .i_valid(i_pix.valid),
        .i_cmd(i_pix.data.cmd), .i_hue(i_pix.data.hue),
        .i_saturation(i_pix.data.saturation), .i_brightness(i_pix.data.brightness),
        .i_temperature(i_pix.data.temperature), .i_fade(i_pix.data.fade),
        .i_led_index(i_pix.data.led_index),
        .o_valid(v_mid), .o_color(c_mid)
    );

    lpcg_correct u_corr (
        .i_clk, .i_rst_n, .i_en(en), .i_gamma_mode(r_gamma_mode),
        .i_valid(v_mid), .i_color(c_mid),
        .o_valid(o_pix.valid), .o_color(c_out)
    );

    assign o_pix.data.out_index = c_out.led_index;
    assign o_pix.data.green     = c_out.green;
    assign o_pix.data.red       = c_out.red;
    assign o_pix.data.blue      = c_out.blue;
endmodule

[hdl/lpcg_checker.sv]
// lpcg_assert: port-level assertions for led_pixel_color_generator, bound to the top.
// Depends on nothing beyond the top level's ports.
`timescale 1ns / 1ps
module lpcg_assert (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output dropped while stalled");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during stall");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("output valid after reset");
endmodule

bind led_pixel_color_generator lpcg_assert u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_ready(i_pix.ready),
    .out_valid(o_pix.valid), .out_ready(o_pix.ready)
);
